// ----- sv/svm_pkg.sv -----
`timescale 1ns / 1ps
package svm_pkg;
	localparam int STACK_DEPTH_DEF = 256;
	localparam int VAR_COUNT_DEF = 256;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int IMM_W = 16;
	localparam int NAME_W = 8;
	localparam int DEPTH_W = 9;

	typedef enum logic [3:0] {
		OP_PUSH = 4'h1,
		OP_DEFINE = 4'h2,
		OP_LOAD = 4'h3,
		OP_STORE = 4'h4,
		OP_ADD = 4'h5,
		OP_SUB = 4'h6,
		OP_MUL = 4'h7,
		OP_DIV = 4'h8,
		OP_OUTPUT = 4'h9
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_FULL = 3'd2,
		ST_DIVZERO = 3'd3,
		ST_UNDEF = 3'd4,
		ST_REDEF = 3'd5,
		ST_DIVOVF = 3'd6,
		ST_BADOP = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_ITER,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd;
		logic check;
		logic iter_start;
		logic iter_step;
		logic finish;
		logic out_valid;
	} cmd_t;

	typedef struct packed {
		logic iter_needed;
		logic iter_done;
	} sts_t;
endpackage

// ----- sv/svm_datapath.sv -----
`timescale 1ns / 1ps
module svm_datapath import svm_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int VAR_COUNT = VAR_COUNT_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output sts_t sts,
	input logic [3:0] op,
	input logic signed [IMM_W-1:0] imm_value,
	input logic [NAME_W-1:0] var_name,
	output logic [2:0] status,
	output logic signed [IMM_W-1:0] value,
	output logic [DEPTH_W-1:0] depth
);
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int VI_W = $clog2(VAR_COUNT);
	localparam int IT_W = $clog2(DATA_WIDTH + 1);

	logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
	logic [DATA_WIDTH-1:0] var_mem [VAR_COUNT];
	logic [VAR_COUNT-1:0] defined_q;
	logic [CNT_W-1:0] count_q;
	logic [3:0] op_q;
	logic [DATA_WIDTH-1:0] imm_q;
	logic [NAME_W-1:0] name_q;
	logic [DATA_WIDTH-1:0] top_q, sec_q, var_q;
	logic [2:0] status_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic [DATA_WIDTH-1:0] acc_q, mcand_q, rem_q, quo_q, dvs_q;
	logic neg_q, mul_q;
	logic [IT_W-1:0] it_q;

	logic [VI_W-1:0] vidx;
	logic name_ok, def;
	logic [SP_W-1:0] top_idx, sec_idx;
	logic [DATA_WIDTH-1:0] a_abs, b_abs;
	logic [DATA_WIDTH:0] rem_sh, rem_sub;
	logic [DATA_WIDTH-1:0] q_s, r_nz;
	logic [DATA_WIDTH-1:0] wr_val;
	logic [2:0] chk_status;

	assign vidx = name_q[VI_W-1:0];
	assign name_ok = (name_q != '0) && ({24'd0, name_q} < 32'(VAR_COUNT));
	assign def = name_ok && defined_q[vidx];
	assign top_idx = SP_W'(count_q - 1'b1);
	assign sec_idx = SP_W'(count_q - 2'd2);
	assign a_abs = sec_q[DATA_WIDTH-1] ? -sec_q : sec_q;
	assign b_abs = top_q[DATA_WIDTH-1] ? -top_q : top_q;

	always_comb begin
		chk_status = ST_OK;
		case (op_q)
			OP_PUSH: if (count_q >= CNT_W'(STACK_DEPTH)) chk_status = ST_FULL;
			OP_DEFINE: begin
				if (!name_ok) chk_status = ST_UNDEF;
				else if (defined_q[vidx]) chk_status = ST_REDEF;
			end
			OP_LOAD: begin
				if (!def) chk_status = ST_UNDEF;
				else if (count_q >= CNT_W'(STACK_DEPTH)) chk_status = ST_FULL;
			end
			OP_STORE: begin
				if (!def) chk_status = ST_UNDEF;
				else if (count_q == '0) chk_status = ST_UNDERFLOW;
			end
			OP_ADD, OP_SUB, OP_MUL: if (count_q < CNT_W'(2)) chk_status = ST_UNDERFLOW;
			OP_DIV: begin
				if (count_q < CNT_W'(2)) chk_status = ST_UNDERFLOW;
				else if (top_q == '0) chk_status = ST_DIVZERO;
				else if (sec_q == {1'b1, {(DATA_WIDTH-1){1'b0}}} && top_q == '1)
					chk_status = ST_DIVOVF;
			end
			OP_OUTPUT: if (!def) chk_status = ST_UNDEF;
			default: chk_status = ST_BADOP;
		endcase
	end

	assign sts.iter_needed = (chk_status == ST_OK) && ((op_q == OP_MUL) || (op_q == OP_DIV));
	assign sts.iter_done = (it_q == '0);

	assign rem_sh = {rem_q, quo_q[DATA_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign q_s = neg_q ? -quo_q : quo_q;
	assign r_nz = (rem_q != '0 && neg_q) ? q_s - 1'b1 : q_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			defined_q <= '0;
			count_q <= '0;
		end else if (cmd.finish && status_q == ST_OK) begin
			case (op_q)
				OP_PUSH, OP_LOAD: count_q <= count_q + 1'b1;
				OP_STORE, OP_ADD, OP_SUB, OP_MUL, OP_DIV: count_q <= count_q - 1'b1;
				OP_DEFINE: defined_q[vidx] <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op;
			imm_q <= DATA_WIDTH'(signed'(imm_value));
			name_q <= var_name;
		end
		if (cmd.rd) begin
			top_q <= stack_mem[top_idx];
			sec_q <= stack_mem[sec_idx];
			var_q <= var_mem[vidx];
		end
	end

	always_comb begin
		wr_val = res_q;
		case (op_q)
			OP_PUSH, OP_DEFINE: wr_val = imm_q;
			OP_LOAD, OP_OUTPUT: wr_val = var_q;
			OP_STORE: wr_val = top_q;
			OP_MUL: wr_val = acc_q;
			OP_DIV: wr_val = r_nz;
			default: wr_val = res_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && status_q == ST_OK) begin
			case (op_q)
				OP_PUSH, OP_LOAD: stack_mem[SP_W'(count_q)] <= wr_val;
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: stack_mem[sec_idx] <= wr_val;
				default: ;
			endcase
		end
		if (cmd.finish && status_q == ST_OK && (op_q == OP_DEFINE || op_q == OP_STORE))
			var_mem[vidx] <= wr_val;
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			status_q <= chk_status;
			case (op_q)
				OP_ADD: res_q <= sec_q + top_q;
				OP_SUB: res_q <= sec_q - top_q;
				default: res_q <= '0;
			endcase
		end
		if (cmd.iter_start) begin
			it_q <= IT_W'(DATA_WIDTH);
			mul_q <= (op_q == OP_MUL);
			acc_q <= '0;
			mcand_q <= sec_q;
			rem_q <= '0;
			quo_q <= (op_q == OP_MUL) ? top_q : a_abs;
			dvs_q <= b_abs;
			neg_q <= sec_q[DATA_WIDTH-1] ^ top_q[DATA_WIDTH-1];
		end else if (cmd.iter_step) begin
			it_q <= it_q - 1'b1;
			if (mul_q) begin
				if (quo_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q <= mcand_q << 1;
				quo_q <= {top_q[DATA_WIDTH-1], quo_q[DATA_WIDTH-1:1]};
			end else if (!rem_sub[DATA_WIDTH]) begin
				rem_q <= rem_sub[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			if (status_q != ST_OK) value_q <= '0;
			else value_q <= wr_val;
		end
	end

	assign status = status_q;
	assign value = IMM_W'(value_q);
	assign depth = DEPTH_W'(count_q);

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH)) else $error("stack count out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(defined_q)) else $error("flags changed outside finish");
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && status_q != ST_OK) |=> $stable(count_q))
		else $error("failed request changed depth");
endmodule

// ----- sv/svm_ctrl.sv -----
`timescale 1ns / 1ps
module svm_ctrl import svm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic out_stall,
	input sts_t sts,
	output cmd_t cmd,
	output logic in_stall
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_fire) state_d = S_READ;
			S_READ: state_d = S_CHECK;
			S_CHECK: state_d = sts.iter_needed ? S_ITER : S_FIN;
			S_ITER: if (sts.iter_done) state_d = S_FIN;
			S_FIN: state_d = S_OUT;
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.capture = in_fire;
			end
			S_READ: cmd.rd = 1'b1;
			S_CHECK: begin
				cmd.check = 1'b1;
				cmd.iter_start = sts.iter_needed;
			end
			S_ITER: cmd.iter_step = !sts.iter_done;
			S_FIN: cmd.finish = 1'b1;
			S_OUT: cmd.out_valid = 1'b1;
			default: ;
		endcase
	end

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.rd, cmd.check, cmd.iter_step, cmd.finish, cmd.out_valid}))
		else $error("overlapping commands");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> cmd.out_valid) else $error("result not presented");
endmodule

// ----- sv/stack_vm_execute_unit.sv -----
`timescale 1ns / 1ps
// Stack machine execute unit. One request on the input channel is one
// instruction (op, imm_value, var_name); each produces exactly one result
// (status, value, depth) on the output channel. Both channels move a
// request at a clock edge where valid is high and stall is low.
// The unit works on one instruction at a time. Push, define, load, store,
// output, add, sub and every failing instruction pass through the capture,
// read, check and finish steps before the result is presented to a receiver.
// Mul and div run a shift-add or restoring divide loop, one bit per cycle,
// between the check and finish steps, before the result is presented.
// Another instruction is taken the cycle after its result is delivered.
// While the receiver stalls, the result stays on the output ports and
// in_stall stays high. Reset clears the stack count and all variable
// defined flags; no clearing pass is needed, so requests are taken from
// the first cycle after reset.
module stack_vm_execute_unit import svm_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int VAR_COUNT = VAR_COUNT_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [3:0] op,
	input logic signed [IMM_W-1:0] imm_value,
	input logic [NAME_W-1:0] var_name,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic signed [IMM_W-1:0] value,
	output logic [DEPTH_W-1:0] depth
);
	cmd_t cmd;
	sts_t sts;
	logic in_fire;

	assign in_fire = in_valid && !in_stall;
	assign out_valid = cmd.out_valid;

	svm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_stall(out_stall),
		.sts(sts), .cmd(cmd), .in_stall(in_stall)
	);

	svm_datapath #(
		.STACK_DEPTH(STACK_DEPTH), .VAR_COUNT(VAR_COUNT), .DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.op(op), .imm_value(imm_value), .var_name(var_name),
		.status(status), .value(value), .depth(depth)
	);
endmodule
